/* rtl/core/uvs_pkg.sv */
`timescale 1ns / 1ps

package uvs_pkg;

  localparam int MAX_DIVISIONS = 256;
  localparam int FRACTION_BITS = 16;

  localparam int N_DIV_CELLS  = 32;
  localparam int N_POLY_CELLS = 5;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [33:0] PI_Q32  = 34'h3_243F_6A88;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_STACK_COUNT   = 2'd0;
  localparam logic [1:0] REG_SECTOR_COUNT  = 2'd1;
  localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

  // Taylor divisors for the sine and cosine Horner steps, with their
  // reciprocals scaled by 2^32.
  localparam logic [6:0] SDIV [N_POLY_CELLS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [6:0] CDIV [N_POLY_CELLS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [31:0] SRCP [N_POLY_CELLS] = '{
    32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
    32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)};
  localparam logic [31:0] CRCP [N_POLY_CELLS] = '{
    32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30),
    32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};

  // Partial state of the two restoring dividers.
  typedef struct packed {
    logic [8:0]  rem_n;
    logic [9:0]  rem_s;
    logic [31:0] q_n;
    logic [31:0] q_s;
    logic        int_n;
  } div_t;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } oct_t;

  typedef struct packed {
    oct_t        stk;
    oct_t        sec;
    logic [16:0] tu;
    logic [16:0] tv;
  } meta_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] ts;
    logic [30:0] tc;
  } lane_t;

  typedef struct packed {
    lane_t stk;
    lane_t sec;
  } poly_t;

  // Shift right with rounding half away from zero.
  function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
                                                    input int unsigned sh);
    logic [63:0] half;
    logic [63:0] mag;
    half = 64'd1 << (sh - 1);
    mag  = v[63] ? 64'(-v) : 64'(v);
    mag  = (mag + half) >> sh;
    return v[63] ? -signed'(mag) : signed'(mag);
  endfunction

endpackage

/* rtl/core/uvs_in_if.sv */
`timescale 1ns / 1ps

interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] stack_index;
  logic [8:0] sector_index;

  modport source (output valid, output stack_index, output sector_index, input ready);
  modport sink (input valid, input stack_index, input sector_index, output ready);
endinterface

/* rtl/core/uvs_out_if.sv */
`timescale 1ns / 1ps

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] pos_x;
  logic signed [24:0] pos_y;
  logic signed [24:0] pos_z;
  logic signed [17:0] norm_x;
  logic signed [17:0] norm_y;
  logic signed [17:0] norm_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output norm_x, output norm_y, output norm_z,
                  output tex_u, output tex_v, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input norm_x, input norm_y, input norm_z,
                input tex_u, input tex_v, output ready);
endinterface

/* rtl/core/uvs_div_cell.sv */
`timescale 1ns / 1ps

module uvs_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [8:0]    div_n,
  input  logic [9:0]    div_s,
  input  logic          valid_in,
  input  uvs_pkg::div_t d_in,
  output logic          valid_out,
  output uvs_pkg::div_t d_out
);
  import uvs_pkg::*;

  logic [9:0]  tn;
  logic [10:0] ts;
  logic        bn;
  logic        bs;
  div_t        d_next;

  // One restoring step for each divider: double, compare, subtract.
  always_comb begin
    tn = {d_in.rem_n, 1'b0};
    ts = {d_in.rem_s, 1'b0};
    bn = tn >= {1'b0, div_n};
    bs = ts >= {1'b0, div_s};
    d_next       = d_in;
    d_next.rem_n = bn ? 9'(tn - {1'b0, div_n}) : tn[8:0];
    d_next.rem_s = bs ? 10'(ts - {1'b0, div_s}) : ts[9:0];
    d_next.q_n   = {d_in.q_n[30:0], bn};
    d_next.q_s   = {d_in.q_s[30:0], bs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

/* rtl/core/uvs_poly_cell.sv */
`timescale 1ns / 1ps

module uvs_poly_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [6:0]     div_s,
  input  logic [6:0]     div_c,
  input  logic [31:0]    rcp_s,
  input  logic [31:0]    rcp_c,
  input  logic           valid_in,
  input  uvs_pkg::poly_t p_in,
  input  uvs_pkg::meta_t m_in,
  output logic           valid_out,
  output uvs_pkg::poly_t p_out,
  output uvs_pkg::meta_t m_out
);
  import uvs_pkg::*;

  // Lanes: 0 stack sine, 1 stack cosine, 2 sector sine, 3 sector cosine.
  logic [30:0] t_in  [4];
  logic [29:0] x2_in [4];
  logic [60:0] prod_a [4];
  logic [63:0] prod_b [4];
  logic [36:0] qd_c  [4];
  logic [31:0] rem_c [4];
  logic [29:0] q_c   [4];
  logic [30:0] t_c   [4];
  logic [31:0] rcp   [4];
  logic [6:0]  dv    [4];

  logic        va;
  logic        vb;
  poly_t       pa;
  poly_t       pb;
  meta_t       ma;
  meta_t       mb;
  logic [30:0] ph_a [4];
  logic [30:0] ph_b [4];
  logic [29:0] q0_b [4];
  poly_t       p_next;

  always_comb begin
    t_in  = '{p_in.stk.ts, p_in.stk.tc, p_in.sec.ts, p_in.sec.tc};
    x2_in = '{p_in.stk.x2, p_in.stk.x2, p_in.sec.x2, p_in.sec.x2};
    rcp   = '{rcp_s, rcp_c, rcp_s, rcp_c};
    dv    = '{div_s, div_c, div_s, div_c};
    for (int k = 0; k < 4; k++) begin
      prod_a[k] = 61'(x2_in[k]) * 61'(t_in[k]);
      prod_b[k] = 64'(ph_a[k]) * 64'(rcp[k]);
      // The reciprocal estimate is at most one short; one correction fixes it.
      qd_c[k]   = 37'(q0_b[k]) * 37'(dv[k]);
      rem_c[k]  = {1'b0, ph_b[k]} - qd_c[k][31:0];
      q_c[k]    = q0_b[k] + 30'(rem_c[k] >= 32'(dv[k]));
      t_c[k]    = 31'(Q30_ONE) - 31'(q_c[k]);
    end
    p_next        = pb;
    p_next.stk.ts = t_c[0];
    p_next.stk.tc = t_c[1];
    p_next.sec.ts = t_c[2];
    p_next.sec.tc = t_c[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      va        <= valid_in;
      vb        <= va;
      valid_out <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= p_in;
      ma <= m_in;
      pb <= pa;
      mb <= ma;
      for (int k = 0; k < 4; k++) begin
        ph_a[k] <= prod_a[k][60:30];
        ph_b[k] <= ph_a[k];
        q0_b[k] <= prod_b[k][61:32];
      end
      p_out <= p_next;
      m_out <= mb;
    end
  end

endmodule

/* rtl/core/uv_sphere_vertex_generator.sv */
`timescale 1ns / 1ps

// Latitude-longitude sphere vertex generator. Each input transaction names a
// grid point by stack index (0 is the top pole) and sector index; the block
// returns one output transaction with the vertex position (signed Q8.16), the
// unit normal (signed Q1.16) and the texture coordinate (Q1.16). Indices above
// their count are clamped to it, and counts of zero or above 256 act as 1 and
// 256. The block is a fully pipelined chain: 32 restoring divider cells form
// the angles and texture coordinates, and five Horner cells of three stages
// each evaluate sine and cosine. It takes one transaction every cycle while the
// chain advances. When the output is stalled the pipeline keeps filling its
// bubbles, so input is still taken while a finished result waits.
// Configuration should be written only while no transaction is in flight.

module uv_sphere_vertex_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_en,
  input  logic [1:0]  write_index,
  input  logic [23:0] write_data,
  uvs_in_if.sink      in_ch,
  uvs_out_if.source   out_ch
);
  import uvs_pkg::*;

  typedef struct packed {
    oct_t        o;
    logic [29:0] r;
  } fold_t;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } sc_t;

  // Octant folding: the residue is reflected about pi/4 when above it, and
  // sine and cosine then swap roles.
  function automatic fold_t fold(input logic [31:0] ph);
    fold_t f;
    f.o.quad = ph[31:30];
    if (ph[29:0] > 30'h2000_0000) begin
      f.r      = 30'(31'h4000_0000 - {1'b0, ph[29:0]});
      f.o.swap = 1'b1;
    end else begin
      f.r      = ph[29:0];
      f.o.swap = 1'b0;
    end
    return f;
  endfunction

  // Quadrant mapping of the base sine and cosine.
  function automatic sc_t unfold(input oct_t o, input logic [30:0] s,
                                 input logic [30:0] c);
    sc_t r;
    logic signed [31:0] bs;
    logic signed [31:0] bc;
    bs = o.swap ? signed'({1'b0, c}) : signed'({1'b0, s});
    bc = o.swap ? signed'({1'b0, s}) : signed'({1'b0, c});
    unique case (o.quad)
      2'd0: begin r.sn = bs;  r.cs = bc;  end
      2'd1: begin r.sn = bc;  r.cs = -bs; end
      2'd2: begin r.sn = -bs; r.cs = -bc; end
      default: begin r.sn = -bc; r.cs = bs; end
    endcase
    return r;
  endfunction

  // Configuration registers.
  logic [8:0]  stack_count;
  logic [8:0]  sector_count;
  logic [23:0] sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= 9'd16;
      sector_count  <= 9'd32;
      sphere_radius <= 24'd65536;
    end else if (write_en) begin
      unique case (write_index)
        REG_STACK_COUNT:   stack_count   <= write_data[8:0];
        REG_SECTOR_COUNT:  sector_count  <= write_data[8:0];
        REG_SPHERE_RADIUS: sphere_radius <= write_data;
        default: ;
      endcase
    end
  end

  // Effective counts and their halves, used throughout the pipeline; the user
  // must change them only while the block is empty; the block does not enforce it.
  logic [8:0] cnt_s;
  logic [8:0] cnt_n;
  logic [8:0] h_s;
  logic [8:0] h_n;
  logic [9:0] div2_s;
  logic signed [24:0] rad;

  always_comb begin
    cnt_s = (stack_count == 9'd0) ? 9'd1 :
            (stack_count > 9'(MAX_DIVISIONS)) ? 9'(MAX_DIVISIONS) : stack_count;
    cnt_n = (sector_count == 9'd0) ? 9'd1 :
            (sector_count > 9'(MAX_DIVISIONS)) ? 9'(MAX_DIVISIONS) : sector_count;
    h_s    = cnt_s >> 1;
    h_n    = cnt_n >> 1;
    // The stack angle spans half a turn, so its divider runs against 2S.
    div2_s = {cnt_s, 1'b0};
    rad    = signed'({1'b0, sphere_radius});
  end

  // Global advance: the chain moves unless a finished result waits in the
  // output register and the last stage also holds one.
  logic en;
  logic v_q5;
  logic out_valid;

  assign en          = !out_valid || out_ch.ready || !v_q5;
  assign in_ch.ready = en;

  // Input stage: clamp the indices and take the integer step of the sector
  // division.
  logic [8:0] i_cl;
  logic [8:0] j_cl;
  div_t       d0_next;

  always_comb begin
    i_cl          = (in_ch.stack_index > cnt_s) ? cnt_s : in_ch.stack_index;
    j_cl          = (in_ch.sector_index > cnt_n) ? cnt_n : in_ch.sector_index;
    d0_next.int_n = (j_cl == cnt_n);
    d0_next.rem_n = (j_cl == cnt_n) ? 9'd0 : j_cl;
    d0_next.rem_s = {1'b0, i_cl};
    d0_next.q_n   = '0;
    d0_next.q_s   = '0;
  end

  logic v_div [N_DIV_CELLS + 1];
  div_t d_div [N_DIV_CELLS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_div[0] <= 1'b0;
    end else if (en) begin
      v_div[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_div[0] <= d0_next;
    end
  end

  for (genvar g = 0; g < N_DIV_CELLS; g++) begin : g_div
    uvs_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .div_n     (cnt_n),
      .div_s     (div2_s),
      .valid_in  (v_div[g]),
      .d_in      (d_div[g]),
      .valid_out (v_div[g + 1]),
      .d_out     (d_div[g + 1])
    );
  end

  // P1: phases with half-up rounding, and the products that recover the
  // 16-bit remainders needed to round the texture coordinates.
  div_t        dq;
  logic        rnd_n;
  logic        rnd_s;
  logic [8:0]  rs_half;

  logic        v_p1;
  logic [31:0] p1_sec;
  logic [31:0] p1_stk;
  logic [24:0] p1_mul_u;
  logic [23:0] p1_mul_v;
  logic [8:0]  p1_rn;
  logic [8:0]  p1_rs;
  logic [15:0] p1_qn_hi;
  logic [16:0] p1_qs_hi;
  logic        p1_int;

  always_comb begin
    dq      = d_div[N_DIV_CELLS];
    rs_half = dq.rem_s[9:1];
    rnd_n   = ({1'b0, dq.rem_n} + {1'b0, h_n}) >= {1'b0, cnt_n};
    rnd_s   = ({1'b0, rs_half} + {1'b0, h_s}) >= {1'b0, cnt_s};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_sec   <= dq.q_n + 32'(rnd_n);
      p1_stk   <= Q30_ONE - (dq.q_s + 32'(rnd_s));
      p1_mul_u <= 25'(cnt_n) * 25'(dq.q_n[15:0]);
      p1_mul_v <= 24'(cnt_s) * 24'(dq.q_s[14:0]);
      p1_rn    <= dq.rem_n;
      p1_rs    <= rs_half;
      p1_qn_hi <= dq.q_n[31:16];
      p1_qs_hi <= dq.q_s[31:15];
      p1_int   <= dq.int_n;
    end
  end

  // P2: texture coordinates and octant folding.
  logic   cmp_u;
  logic   cmp_v;
  fold_t  f_stk;
  fold_t  f_sec;

  logic        v_p2;
  meta_t       p2_meta;
  logic [29:0] p2_r_stk;
  logic [29:0] p2_r_sec;

  always_comb begin
    cmp_u = (26'(p1_rn) + 26'(p1_mul_u)) >= (26'(cnt_n - h_n) << 16);
    cmp_v = (25'(p1_rs) + 25'(p1_mul_v)) >= (25'(cnt_s - h_s) << 15);
    f_stk = fold(p1_stk);
    f_sec = fold(p1_sec);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_meta.tu  <= {p1_int, p1_qn_hi} + 17'(cmp_u);
      p2_meta.tv  <= p1_qs_hi + 17'(cmp_v);
      p2_meta.stk <= f_stk.o;
      p2_meta.sec <= f_sec.o;
      p2_r_stk    <= f_stk.r;
      p2_r_sec    <= f_sec.r;
    end
  end

  // P3: residue times pi.
  logic        v_p3;
  meta_t       p3_meta;
  logic [63:0] p3_pr_stk;
  logic [63:0] p3_pr_sec;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_meta   <= p2_meta;
      p3_pr_stk <= 64'(p2_r_stk) * 64'(PI_Q32);
      p3_pr_sec <= 64'(p2_r_sec) * 64'(PI_Q32);
    end
  end

  // P4: angle in Q30 radians.
  logic        v_p4;
  meta_t       p4_meta;
  logic [29:0] p4_x_stk;
  logic [29:0] p4_x_sec;
  logic [64:0] xr_stk;
  logic [64:0] xr_sec;

  always_comb begin
    xr_stk = (65'(p3_pr_stk) + (65'd1 << 32)) >> 33;
    xr_sec = (65'(p3_pr_sec) + (65'd1 << 32)) >> 33;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_meta  <= p3_meta;
      p4_x_stk <= xr_stk[29:0];
      p4_x_sec <= xr_sec[29:0];
    end
  end

  // P5: square of the angle.
  logic        v_p5;
  meta_t       p5_meta;
  logic [29:0] p5_x_stk;
  logic [29:0] p5_x_sec;
  logic [59:0] p5_sq_stk;
  logic [59:0] p5_sq_sec;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_meta   <= p4_meta;
      p5_x_stk  <= p4_x_stk;
      p5_x_sec  <= p4_x_sec;
      p5_sq_stk <= 60'(p4_x_stk) * 60'(p4_x_stk);
      p5_sq_sec <= 60'(p4_x_sec) * 60'(p4_x_sec);
    end
  end

  // P6: rounded square and the starting Horner terms of one.
  logic [60:0] x2r_stk;
  logic [60:0] x2r_sec;
  logic        v_pc [N_POLY_CELLS + 1];
  poly_t       p_pc [N_POLY_CELLS + 1];
  meta_t       m_pc [N_POLY_CELLS + 1];

  always_comb begin
    x2r_stk = (61'(p5_sq_stk) + (61'd1 << 29)) >> 30;
    x2r_sec = (61'(p5_sq_sec) + (61'd1 << 29)) >> 30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_pc[0]        <= p5_meta;
      p_pc[0].stk.x  <= p5_x_stk;
      p_pc[0].stk.x2 <= x2r_stk[29:0];
      p_pc[0].stk.ts <= 31'(Q30_ONE);
      p_pc[0].stk.tc <= 31'(Q30_ONE);
      p_pc[0].sec.x  <= p5_x_sec;
      p_pc[0].sec.x2 <= x2r_sec[29:0];
      p_pc[0].sec.ts <= 31'(Q30_ONE);
      p_pc[0].sec.tc <= 31'(Q30_ONE);
    end
  end

  for (genvar g = 0; g < N_POLY_CELLS; g++) begin : g_poly
    uvs_poly_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .div_s     (SDIV[g]),
      .div_c     (CDIV[g]),
      .rcp_s     (SRCP[g]),
      .rcp_c     (CRCP[g]),
      .valid_in  (v_pc[g]),
      .p_in      (p_pc[g]),
      .m_in      (m_pc[g]),
      .valid_out (v_pc[g + 1]),
      .p_out     (p_pc[g + 1]),
      .m_out     (m_pc[g + 1])
    );
  end

  // Q1: sine is the angle times its Horner result; cosine is taken as is.
  poly_t       pq;
  logic [60:0] sp_stk;
  logic [60:0] sp_sec;

  logic        v_q1;
  meta_t       q1_meta;
  logic [30:0] q1_s_stk;
  logic [30:0] q1_c_stk;
  logic [30:0] q1_s_sec;
  logic [30:0] q1_c_sec;

  always_comb begin
    pq     = p_pc[N_POLY_CELLS];
    sp_stk = 61'(pq.stk.x) * 61'(pq.stk.ts);
    sp_sec = 61'(pq.sec.x) * 61'(pq.sec.ts);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_meta  <= m_pc[N_POLY_CELLS];
      q1_s_stk <= sp_stk[60:30];
      q1_c_stk <= pq.stk.tc;
      q1_s_sec <= sp_sec[60:30];
      q1_c_sec <= pq.sec.tc;
    end
  end

  // Q2: signed sine and cosine in all four quadrants.
  logic               v_q2;
  logic [16:0]        q2_tu;
  logic [16:0]        q2_tv;
  sc_t                q2_stk;
  sc_t                q2_sec;

  always_ff @(posedge clk) begin
    if (en) begin
      q2_tu  <= q1_meta.tu;
      q2_tv  <= q1_meta.tv;
      q2_stk <= unfold(q1_meta.stk, q1_s_stk, q1_c_stk);
      q2_sec <= unfold(q1_meta.sec, q1_s_sec, q1_c_sec);
    end
  end

  // Q3: direction products in Q60.
  logic               v_q3;
  logic [16:0]        q3_tu;
  logic [16:0]        q3_tv;
  logic signed [31:0] q3_ts;
  logic signed [63:0] q3_px;
  logic signed [63:0] q3_py;

  always_ff @(posedge clk) begin
    if (en) begin
      q3_tu <= q2_tu;
      q3_tv <= q2_tv;
      q3_ts <= q2_stk.sn;
      q3_px <= 64'(q2_stk.cs) * 64'(q2_sec.cs);
      q3_py <= 64'(q2_stk.cs) * 64'(q2_sec.sn);
    end
  end

  // Q4: normals at the output precision, and the direction in Q30 for the
  // position products.
  logic signed [63:0] rx_n;
  logic signed [63:0] ry_n;
  logic signed [63:0] rz_n;
  logic signed [63:0] rx_30;
  logic signed [63:0] ry_30;

  logic               v_q4;
  logic [16:0]        q4_tu;
  logic [16:0]        q4_tv;
  logic signed [31:0] q4_ts;
  logic signed [17:0] q4_nx;
  logic signed [17:0] q4_ny;
  logic signed [17:0] q4_nz;
  logic signed [31:0] q4_px30;
  logic signed [31:0] q4_py30;

  always_comb begin
    rx_n  = round_away(q3_px, 60 - FRACTION_BITS);
    ry_n  = round_away(q3_py, 60 - FRACTION_BITS);
    rz_n  = round_away(64'(q3_ts), 30 - FRACTION_BITS);
    rx_30 = round_away(q3_px, 30);
    ry_30 = round_away(q3_py, 30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q4_tu   <= q3_tu;
      q4_tv   <= q3_tv;
      q4_ts   <= q3_ts;
      q4_nx   <= rx_n[17:0];
      q4_ny   <= ry_n[17:0];
      q4_nz   <= rz_n[17:0];
      q4_px30 <= rx_30[31:0];
      q4_py30 <= ry_30[31:0];
    end
  end

  // Q5: scale by the radius.
  logic [16:0]        q5_tu;
  logic [16:0]        q5_tv;
  logic signed [17:0] q5_nx;
  logic signed [17:0] q5_ny;
  logic signed [17:0] q5_nz;
  logic signed [63:0] q5_px;
  logic signed [63:0] q5_py;
  logic signed [63:0] q5_pz;

  always_ff @(posedge clk) begin
    if (en) begin
      q5_tu <= q4_tu;
      q5_tv <= q4_tv;
      q5_nx <= q4_nx;
      q5_ny <= q4_ny;
      q5_nz <= q4_nz;
      q5_px <= 64'(q4_px30) * 64'(rad);
      q5_py <= 64'(q4_py30) * 64'(rad);
      q5_pz <= 64'(q4_ts) * 64'(rad);
    end
  end

  // Valid bits of the stages kept in this module.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_p1    <= 1'b0;
      v_p2    <= 1'b0;
      v_p3    <= 1'b0;
      v_p4    <= 1'b0;
      v_p5    <= 1'b0;
      v_pc[0] <= 1'b0;
      v_q1    <= 1'b0;
      v_q2    <= 1'b0;
      v_q3    <= 1'b0;
      v_q4    <= 1'b0;
      v_q5    <= 1'b0;
    end else if (en) begin
      v_p1    <= v_div[N_DIV_CELLS];
      v_p2    <= v_p1;
      v_p3    <= v_p2;
      v_p4    <= v_p3;
      v_p5    <= v_p4;
      v_pc[0] <= v_p5;
      v_q1    <= v_pc[N_POLY_CELLS];
      v_q2    <= v_q1;
      v_q3    <= v_q2;
      v_q4    <= v_q3;
      v_q5    <= v_q4;
    end
  end

  // Output register: loads whenever it is empty or being taken, so a waiting
  // result is never overwritten.
  logic signed [63:0] ox;
  logic signed [63:0] oy;
  logic signed [63:0] oz;
  logic               out_load;

  always_comb begin
    ox       = round_away(q5_px, 30);
    oy       = round_away(q5_py, 30);
    oz       = round_away(q5_pz, 30);
    out_load = !out_valid || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= v_q5;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.pos_x  <= ox[24:0];
      out_ch.pos_y  <= oy[24:0];
      out_ch.pos_z  <= oz[24:0];
      out_ch.norm_x <= q5_nx;
      out_ch.norm_y <= q5_ny;
      out_ch.norm_z <= q5_nz;
      out_ch.tex_u  <= q5_tu;
      out_ch.tex_v  <= q5_tv;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

/* tb/tb_uv_sphere_vertex_generator.sv */
`timescale 1ns / 1ps

// Testbench for the latitude-longitude sphere vertex generator. An internal
// predictor works out the position, normal and texture coordinate of every
// accepted input transaction. Each output transaction is compared field by
// field with the oldest prediction still waiting.

module tb_uv_sphere_vertex_generator;
  import uvs_pkg::*;

  localparam int PIPE_LATENCY = 60;

  typedef struct packed {
    logic signed [24:0] pos_x;
    logic signed [24:0] pos_y;
    logic signed [24:0] pos_z;
    logic signed [17:0] norm_x;
    logic signed [17:0] norm_y;
    logic signed [17:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } vertex_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        write_en = 1'b0;
  logic [1:0]  write_index = REG_STACK_COUNT;
  logic [23:0] write_data = '0;

  uvs_in_if  in_ch ();
  uvs_out_if out_ch ();

  uv_sphere_vertex_generator dut (
    .clk(clk), .rst(rst), .write_en(write_en), .write_index(write_index),
    .write_data(write_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // The testbench's own copy of the configuration registers.
  logic [8:0]  stacks_cfg  = 9'd16;
  logic [8:0]  sectors_cfg = 9'd32;
  logic [23:0] radius_cfg  = 24'd65536;

  vertex_t expected_vertices[$];
  bit      failed = 1'b0;
  int      stall_percent = 30;
  int      ready_hold = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.stack_index = '0;
    in_ch.sector_index = '0;
    out_ch.ready = 1'b0;
  end

  // Half away from zero rounding of a right shift.
  function automatic longint shift_round(longint v, int sh);
    longint unsigned mag;
    mag = v < 0 ? longint'(-v) : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  // Truncated Taylor series of sine and cosine for 0 <= x <= pi/4, in Q30.
  function automatic void taylor_sin_cos(longint unsigned x,
                                         output longint unsigned s,
                                         output longint unsigned c);
    longint unsigned sine_div[5] = '{110, 72, 42, 20, 6};
    longint unsigned cos_div[5]  = '{90, 56, 30, 12, 2};
    longint unsigned x2, t;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t = 64'd1 << 30;
    for (int k = 0; k < 5; k++) t = (64'd1 << 30) - (((x2 * t) / sine_div[k]) >> 30);
    s = (x * t) >> 30;
    t = 64'd1 << 30;
    for (int k = 0; k < 5; k++) t = (64'd1 << 30) - (((x2 * t) / cos_div[k]) >> 30);
    c = t;
  endfunction

  // Sine and cosine of a phase in turns (2^32 is one turn), signed Q30.
  function automatic void phase_sin_cos(logic [31:0] phase, output longint sn,
                                        output longint cs);
    longint unsigned r, x, s, c;
    longint bs, bc;
    bit swap;
    r = phase[29:0];
    swap = r > (64'd1 << 29);
    if (swap) r = (64'd1 << 30) - r;
    x = (r * 64'h3_243F_6A88 + (64'd1 << 32)) >> 33;
    taylor_sin_cos(x, s, c);
    bs = swap ? c : s;
    bc = swap ? s : c;
    case (phase[31:30])
      2'd0: begin sn = bs;  cs = bc;  end
      2'd1: begin sn = bc;  cs = -bs; end
      2'd2: begin sn = -bs; cs = -bc; end
      default: begin sn = -bc; cs = bs; end
    endcase
  endfunction

  function automatic longint unsigned effective_divisions(logic [8:0] n);
    if (n == 0) return 1;
    if (n > 256) return 256;
    return n;
  endfunction

  function automatic vertex_t sphere_vertex(logic [8:0] stack_idx, logic [8:0] sector_idx);
    longint unsigned nst, nsec, i, j;
    logic [31:0] sec_phase, stk_phase;
    longint ts, tc, ss, sc, px30, py30;
    vertex_t v;
    nst = effective_divisions(stacks_cfg);
    nsec = effective_divisions(sectors_cfg);
    i = stack_idx > nst ? nst : stack_idx;
    j = sector_idx > nsec ? nsec : sector_idx;
    sec_phase = 32'(((j << 32) + nsec / 2) / nsec);
    stk_phase = 32'((64'd1 << 30) - (((i << 31) + nst / 2) / nst));
    phase_sin_cos(stk_phase, ts, tc);
    phase_sin_cos(sec_phase, ss, sc);
    v.norm_x = 18'(shift_round(tc * sc, 44));
    v.norm_y = 18'(shift_round(tc * ss, 44));
    v.norm_z = 18'(shift_round(ts, 14));
    px30 = shift_round(tc * sc, 30);
    py30 = shift_round(tc * ss, 30);
    v.pos_x = 25'(shift_round(px30 * longint'(radius_cfg), 30));
    v.pos_y = 25'(shift_round(py30 * longint'(radius_cfg), 30));
    v.pos_z = 25'(shift_round(ts * longint'(radius_cfg), 30));
    v.tex_u = 17'(((j << 16) + nsec / 2) / nsec);
    v.tex_v = 17'(((i << 16) + nst / 2) / nst);
    return v;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(99) < 4) return $urandom_range(40, 10);
    return $urandom_range(2);
  endfunction

  // Appends a prediction at the back of the queue.
  function automatic void queue_expected(vertex_t v);
    expected_vertices.insert(expected_vertices.size(), v);
  endfunction

  // Sends one grid point and records its prediction at acceptance. The valid
  // line stays high after acceptance so that points can follow back to back.
  task automatic send_point(logic [8:0] stack_idx, logic [8:0] sector_idx, bit idle = 1'b1);
    int gap;
    gap = idle ? gap_length() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.stack_index <= stack_idx;
    in_ch.sector_index <= sector_idx;
    do @(posedge clk); while (!in_ch.ready);
    queue_expected(sphere_vertex(stack_idx, sector_idx));
  endtask

  // Stops sending and waits until every expected result is back.
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
  endtask

  // Waits until every result is back, plus the pipeline depth.
  task automatic drain();
    wait_results();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [23:0] value);
    write_en <= 1'b1;
    write_index <= idx;
    write_data <= value;
    @(posedge clk);
    case (idx)
      REG_STACK_COUNT:  stacks_cfg = value[8:0];
      REG_SECTOR_COUNT: sectors_cfg = value[8:0];
      default:          radius_cfg = value;
    endcase
  endtask

  task automatic configure(logic [8:0] stacks, logic [8:0] sectors, logic [23:0] radius);
    drain();
    write_register(REG_STACK_COUNT, {15'd0, stacks});
    write_register(REG_SECTOR_COUNT, {15'd0, sectors});
    write_register(REG_SPHERE_RADIUS, radius);
    write_en <= 1'b0;
  endtask

  // Poles, equator, the wrap seam and clamped indices under the reset setting.
  task automatic test_reset_defaults();
    send_point(9'd0, 9'd0);
    send_point(9'd16, 9'd5);
    send_point(9'd8, 9'd0);
    send_point(9'd8, 9'd32);
    send_point(9'd8, 9'd8);
    send_point(9'd3, 9'd27);
    send_point(9'd511, 9'd511);
    send_point(9'd256, 9'd256);
  endtask

  // Extreme counts: zero acts as one, above 256 acts as 256; largest radius in the first two settings.
  task automatic test_count_extremes();
    configure(9'd0, 9'd0, 24'hFFFFFF);
    send_point(9'd0, 9'd0);
    send_point(9'd1, 9'd1);
    send_point(9'd300, 9'd300);
    configure(9'd511, 9'd257, 24'hFFFFFF);
    send_point(9'd0, 9'd1);
    send_point(9'd128, 9'd64);
    send_point(9'd255, 9'd255);
    send_point(9'd256, 9'd256);
    send_point(9'd511, 9'd170);
    configure(9'd256, 9'd256, 24'hAAAAAA);
    send_point(9'd85, 9'd170);
    send_point(9'd170, 9'd85);
  endtask

  // Zero radius keeps the normals, positions are zero.
  task automatic test_zero_radius();
    configure(9'd1, 9'd1, 24'd0);
    send_point(9'd0, 9'd0);
    send_point(9'd1, 9'd1);
    configure(9'd7, 9'd3, 24'd0);
    send_point(9'd4, 9'd2);
    send_point(9'd9, 9'd4);
  endtask

  // Random grid points over several settings; the output side stalls harder
  // in some phases so that the back pressure reaches the input.
  task automatic test_random_points();
    logic [8:0] nst, nsec;
    for (int phase = 0; phase < 10; phase++) begin
      nst = phase == 0 ? 9'd256 : (phase == 1 ? 9'd1 : 9'($urandom_range(511)));
      nsec = phase == 0 ? 9'd256 : (phase == 1 ? 9'd1 : 9'($urandom_range(511)));
      configure(nst, nsec, phase < 2 ? 24'hFFFFFF : 24'($urandom));
      stall_percent = (phase % 3 == 0) ? 0 : (phase % 3 == 1 ? 20 : 70);
      for (int k = 0; k < 112; k++) begin
        if ($urandom_range(9) == 0)
          send_point(9'($urandom), 9'($urandom), phase != 3);
        else
          send_point(9'($urandom_range(effective_divisions(nst))),
                     9'($urandom_range(effective_divisions(nsec))), phase != 3);
        // Once per phase, hold off until everything has come back.
        if (k == 60) wait_results();
      end
    end
    stall_percent = 30;
  endtask

  // Output side: random stalls, now and then a long one, and the check of
  // each result.
  always @(posedge clk) begin
    vertex_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.norm_x, out_ch.norm_y,
                out_ch.norm_z, out_ch.tex_u, out_ch.tex_v};
        if (expected_vertices.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, got);
          failed = 1'b1;
        end else begin
          want = expected_vertices.pop_front();
          if (got.pos_x !== want.pos_x) begin
            $display("%0t: pos_x expected %0d got %0d", $time, want.pos_x, got.pos_x);
            failed = 1'b1;
          end
          if (got.pos_y !== want.pos_y) begin
            $display("%0t: pos_y expected %0d got %0d", $time, want.pos_y, got.pos_y);
            failed = 1'b1;
          end
          if (got.pos_z !== want.pos_z) begin
            $display("%0t: pos_z expected %0d got %0d", $time, want.pos_z, got.pos_z);
            failed = 1'b1;
          end
          if (got.norm_x !== want.norm_x) begin
            $display("%0t: norm_x expected %0d got %0d", $time, want.norm_x, got.norm_x);
            failed = 1'b1;
          end
          if (got.norm_y !== want.norm_y) begin
            $display("%0t: norm_y expected %0d got %0d", $time, want.norm_y, got.norm_y);
            failed = 1'b1;
          end
          if (got.norm_z !== want.norm_z) begin
            $display("%0t: norm_z expected %0d got %0d", $time, want.norm_z, got.norm_z);
            failed = 1'b1;
          end
          if (got.tex_u !== want.tex_u) begin
            $display("%0t: tex_u expected %0d got %0d", $time, want.tex_u, got.tex_u);
            failed = 1'b1;
          end
          if (got.tex_v !== want.tex_v) begin
            $display("%0t: tex_v expected %0d got %0d", $time, want.tex_v, got.tex_v);
            failed = 1'b1;
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold = ready_hold - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(199) == 0) begin
        ready_hold = $urandom_range(40, 10);
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < 3)
        out_ch.ready <= 1'b0;
      else
        out_ch.ready <= $urandom_range(99) >= stall_percent;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_count_extremes();
    test_zero_radius();
    test_random_points();
    drain();
    if (!failed && expected_vertices.size() == 0)
      $display("tb_uv_sphere_vertex_generator OK");
    else
      $display("tb_uv_sphere_vertex_generator NOT OK");
    $finish;
  end

  // Generous bound on the whole run.
  initial begin
    #2000000;
    $display("tb_uv_sphere_vertex_generator NOT OK");
    $finish;
  end

endmodule
